[sv/assert_macros.svh]
// Assertion macros shared by the RTL; clock and reset are the block's port names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define GRD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define GRD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[sv/grd_pkg.sv]
package grd_pkg;

   localparam int BYTE_W    = 8;
   localparam int STICKS    = 4;
   localparam int MAG_W     = 7;
   localparam int NUM_W     = 2 * MAG_W;
   localparam int DIV_STEPS = MAG_W;
   localparam int CNT_W     = 3;

   localparam logic [BYTE_W-1:0] ANALOG_ID = 8'hCE;
   localparam logic [BYTE_W-1:0] BYTE_MAX  = 8'd255;
   localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(DIV_STEPS - 1);

   typedef logic [STICKS-1:0][BYTE_W-1:0] stick_bytes_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic prep;
      logic step;
      logic publish;
   } dp_cmd_type;

   typedef struct packed {
      logic div_last;
   } dp_status_type;

   function automatic logic [BYTE_W-1:0] flip_byte(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] r;
      for (int i = 0; i < BYTE_W; i++) begin
         r[BYTE_W-1-i] = b[i];
      end
      return r;
   endfunction

endpackage

[sv/gamepad_report_decoder.sv]
// Gamepad poll-response decoder.
// Input channel req_*: one beat per received poll response (id byte, two
// active-low button bytes, four bit-reversed stick bytes). Result channel
// rsp_*: one beat per request with the active-high buttons, the analog flag
// on rsp_tuser, the four restored stick bytes and their signed scaled values.
// Each stick is scaled around a stored center: delta clamped to the center's
// range, times 127, divided by the range. The divide runs in four lanes of a
// restoring divider, one quotient bit per cycle. req_tready is high only
// between items: no new request is taken while one is being decoded.
// A finished result waits in the output register; the next request is taken
// while it waits, and a new result is held back until that beat is taken.
// Reset clears the analog history and the four centers to zero and empties
// the output register. Entering analog mode (id 0xCE after any other id)
// captures the centers from that response, so its scaled values are zero.
`include "assert_macros.svh"

module gamepad_report_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // id_byte, buttons_low_byte, buttons_high_byte, right_horiz_byte,
   // right_vert_byte, left_horiz_byte, left_vert_byte
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pressed_buttons, right_horiz_raw, right_vert_raw, left_horiz_raw,
   // left_vert_raw, right_horiz_scaled, right_vert_scaled,
   // left_horiz_scaled, left_vert_scaled
   output logic [79:0] rsp_tdata,
   // analog_active
   output logic        rsp_tuser
);
   import grd_pkg::*;

   dp_cmd_type          cmd;
   dp_status_type       status;
   stick_bytes_type     stick_bytes;
   stick_bytes_type     stick_raw;
   stick_bytes_type     stick_scaled;
   logic [2*BYTE_W-1:0] pressed_buttons;

   assign stick_bytes = req_tdata[55:24];

   grd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   grd_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .id_byte           (req_tdata[7:0]),
      .buttons_low_byte  (req_tdata[15:8]),
      .buttons_high_byte (req_tdata[23:16]),
      .stick_bytes       (stick_bytes),
      .pressed_buttons   (pressed_buttons),
      .analog_active     (rsp_tuser),
      .stick_raw         (stick_raw),
      .stick_scaled      (stick_scaled)
   );

   assign rsp_tdata = {stick_scaled, stick_raw, pressed_buttons};

   `GRD_ASSERT(a_capture_then_prep, cmd.capture |=> cmd.prep, "capture not followed by prep")
   `GRD_ASSERT(a_publish_slot_free, cmd.publish |-> (!rsp_tvalid || rsp_tready), "result overwritten")
   `GRD_ASSERT(a_no_accept_in_div, cmd.step |-> !req_tready, "request taken during divide")
   `GRD_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "output valid after reset")

endmodule

[sv/grd_ctrl.sv]
module grd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  grd_pkg::dp_status_type status,
   output grd_pkg::dp_cmd_type    cmd
);
   import grd_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (status.div_last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // load the output beat once the slot is free or draining
            if (!out_valid_ff || rsp_tready) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.publish) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;

endmodule

[sv/grd_datapath.sv]
module grd_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  grd_pkg::dp_cmd_type           cmd,
   output grd_pkg::dp_status_type        status,
   input  logic [grd_pkg::BYTE_W-1:0]    id_byte,
   input  logic [grd_pkg::BYTE_W-1:0]    buttons_low_byte,
   input  logic [grd_pkg::BYTE_W-1:0]    buttons_high_byte,
   input  grd_pkg::stick_bytes_type      stick_bytes,
   output logic [2*grd_pkg::BYTE_W-1:0]  pressed_buttons,
   output logic                          analog_active,
   output grd_pkg::stick_bytes_type      stick_raw,
   output grd_pkg::stick_bytes_type      stick_scaled
);
   import grd_pkg::*;

   // state across items
   logic                        was_analog_ff, was_analog_in;
   stick_bytes_type             centers_ff, centers_in;

   // captured item
   logic [2*BYTE_W-1:0]         buttons_ff, buttons_in;
   logic                        analog_ff, analog_in;
   stick_bytes_type             raw_ff, raw_in;
   stick_bytes_type             flipped;

   // divider lanes
   logic [STICKS-1:0][MAG_W-1:0] rem_ff, rem_in;
   logic [STICKS-1:0][MAG_W-1:0] low_ff, low_in;
   logic [STICKS-1:0][MAG_W-1:0] den_ff, den_in;
   logic [STICKS-1:0][MAG_W-1:0] quo_ff, quo_in;
   logic [STICKS-1:0]            neg_ff, neg_in;
   logic [STICKS-1:0]            zero_ff, zero_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;

   // result register
   logic [2*BYTE_W-1:0]         out_buttons_ff, out_buttons_in;
   logic                        out_analog_ff, out_analog_in;
   stick_bytes_type             out_raw_ff, out_raw_in;
   stick_bytes_type             out_scaled_ff, out_scaled_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         was_analog_ff <= 1'b0;
         centers_ff    <= '0;
      end else begin
         was_analog_ff <= was_analog_in;
         centers_ff    <= centers_in;
      end
   end

   always_ff @(posedge clock) begin
      buttons_ff     <= buttons_in;
      analog_ff      <= analog_in;
      raw_ff         <= raw_in;
      rem_ff         <= rem_in;
      low_ff         <= low_in;
      den_ff         <= den_in;
      quo_ff         <= quo_in;
      neg_ff         <= neg_in;
      zero_ff        <= zero_in;
      cnt_ff         <= cnt_in;
      out_buttons_ff <= out_buttons_in;
      out_analog_ff  <= out_analog_in;
      out_raw_ff     <= out_raw_in;
      out_scaled_ff  <= out_scaled_in;
   end

   always_comb begin
      logic [BYTE_W-1:0]   ctr;
      logic [BYTE_W-1:0]   rng8;
      logic [MAG_W-1:0]    rng;
      logic signed [BYTE_W:0] delta;
      logic [BYTE_W:0]     abs_d;
      logic [MAG_W-1:0]    mag;
      logic [NUM_W-1:0]    num;
      logic [MAG_W:0]      trial;
      logic [MAG_W:0]      diff;
      logic                ge;
      logic [BYTE_W-1:0]   q8;

      ctr   = '0;
      rng8  = '0;
      rng   = '0;
      delta = '0;
      abs_d = '0;
      mag   = '0;
      num   = '0;
      trial = '0;
      diff  = '0;
      ge    = 1'b0;
      q8    = '0;

      was_analog_in  = was_analog_ff;
      centers_in     = centers_ff;
      buttons_in     = buttons_ff;
      analog_in      = analog_ff;
      raw_in         = raw_ff;
      rem_in         = rem_ff;
      low_in         = low_ff;
      den_in         = den_ff;
      quo_in         = quo_ff;
      neg_in         = neg_ff;
      zero_in        = zero_ff;
      cnt_in         = cnt_ff;
      out_buttons_in = out_buttons_ff;
      out_analog_in  = out_analog_ff;
      out_raw_in     = out_raw_ff;
      out_scaled_in  = out_scaled_ff;

      for (int i = 0; i < STICKS; i++) begin
         flipped[i] = flip_byte(stick_bytes[i]);
      end

      if (cmd.capture) begin
         buttons_in    = ~{buttons_high_byte, buttons_low_byte};
         analog_in     = (id_byte == ANALOG_ID);
         raw_in        = flipped;
         was_analog_in = analog_in;
         // analog mode just began: take this response as the centers
         if (analog_in && !was_analog_ff) begin
            centers_in = flipped;
         end
      end

      if (cmd.prep) begin
         cnt_in = '0;
         for (int i = 0; i < STICKS; i++) begin
            ctr   = centers_ff[i];
            rng8  = ctr[BYTE_W-1] ? (BYTE_MAX - ctr) : ctr;
            rng   = rng8[MAG_W-1:0];
            delta = $signed({1'b0, raw_ff[i]}) - $signed({1'b0, ctr});
            abs_d = delta[BYTE_W] ? (BYTE_W+1)'(-delta) : (BYTE_W+1)'(delta);
            // clamp magnitude to the range of this stick
            mag   = (abs_d > {2'b00, rng}) ? rng : abs_d[MAG_W-1:0];
            num   = {mag, {MAG_W{1'b0}}} - {{MAG_W{1'b0}}, mag};
            rem_in[i]  = num[NUM_W-1:MAG_W];
            low_in[i]  = num[MAG_W-1:0];
            den_in[i]  = rng;
            quo_in[i]  = '0;
            neg_in[i]  = delta[BYTE_W];
            zero_in[i] = (rng == '0);
         end
      end

      if (cmd.step) begin
         cnt_in = cnt_ff + 1'b1;
         for (int i = 0; i < STICKS; i++) begin
            trial     = {rem_ff[i], low_ff[i][MAG_W-1]};
            ge        = (trial >= {1'b0, den_ff[i]});
            diff      = trial - {1'b0, den_ff[i]};
            rem_in[i] = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
            low_in[i] = {low_ff[i][MAG_W-2:0], 1'b0};
            quo_in[i] = {quo_ff[i][MAG_W-2:0], ge};
         end
      end

      if (cmd.publish) begin
         out_buttons_in = buttons_ff;
         out_analog_in  = analog_ff;
         out_raw_in     = raw_ff;
         for (int i = 0; i < STICKS; i++) begin
            q8 = {1'b0, quo_ff[i]};
            if (zero_ff[i]) begin
               out_scaled_in[i] = '0;
            end else if (neg_ff[i]) begin
               out_scaled_in[i] = BYTE_W'(-q8);
            end else begin
               out_scaled_in[i] = q8;
            end
         end
      end
   end

   assign status.div_last = (cnt_ff == DIV_LAST);

   assign pressed_buttons = out_buttons_ff;
   assign analog_active   = out_analog_ff;
   assign stick_raw       = out_raw_ff;
   assign stick_scaled    = out_scaled_ff;

endmodule

[dv/report_checker.sv]
`timescale 1ns / 1ps

module report_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // id_byte, buttons_low_byte, buttons_high_byte, right_horiz_byte,
   // right_vert_byte, left_horiz_byte, left_vert_byte
   input  logic [55:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pressed_buttons, right_horiz_raw, right_vert_raw, left_horiz_raw,
   // left_vert_raw, right_horiz_scaled, right_vert_scaled,
   // left_horiz_scaled, left_vert_scaled
   input  logic [79:0] rsp_tdata,
   // analog_active
   input  logic        rsp_tuser,
   output int          fail_count,
   output int          pending
);
   import grd_pkg::*;

   typedef struct packed {
      logic [15:0]     pressed;
      logic            analog;
      stick_bytes_type raw;
      stick_bytes_type scaled;
   } decoded_report_type;

   decoded_report_type expected_reports[$];
   logic            in_analog;
   stick_bytes_type centers;
   int              mismatches = 0;
   string           lane_name[STICKS] = '{"right_horiz", "right_vert", "left_horiz",
                                          "left_vert"};

   function automatic logic [BYTE_W-1:0] mirror_byte(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] r;
      for (int i = 0; i < BYTE_W; i++) begin
         r[i] = b[BYTE_W-1-i];
      end
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] scale_to_center(input logic [BYTE_W-1:0] pos,
                                                         input logic [BYTE_W-1:0] ctr);
      int p;
      int c;
      int span;
      int d;
      p = pos;
      c = ctr;
      span = (c > 127) ? 255 - c : c;
      if (span == 0) begin
         return '0;
      end
      d = p - c;
      if (d > span) d = span;
      if (d < -span) d = -span;
      return BYTE_W'((d * 127) / span);
   endfunction

   // Updates the analog history and the centers as the block does.
   function automatic decoded_report_type predict_report(input logic [55:0] beat);
      decoded_report_type r;
      logic analog;
      analog = (beat[7:0] == ANALOG_ID);
      r.pressed = ~beat[23:8];
      r.analog = analog;
      for (int s = 0; s < STICKS; s++) begin
         r.raw[s] = mirror_byte(beat[24 + BYTE_W*s +: BYTE_W]);
      end
      // capture centers on entry to analog mode, before scaling this beat
      if (analog && !in_analog) begin
         centers = r.raw;
      end
      in_analog = analog;
      for (int s = 0; s < STICKS; s++) begin
         r.scaled[s] = scale_to_center(r.raw[s], centers[s]);
      end
      return r;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      decoded_report_type want;
      if (reset) begin
         in_analog = 1'b0;
         centers = '0;
         expected_reports.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            expected_reports.push_back(predict_report(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_reports.size() == 0) begin
               $error("result beat with no report outstanding");
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               check_field("pressed_buttons", want.pressed, rsp_tdata[15:0]);
               check_field("analog_active", want.analog, rsp_tuser);
               for (int s = 0; s < STICKS; s++) begin
                  check_field({lane_name[s], "_raw"}, want.raw[s],
                              rsp_tdata[16 + BYTE_W*s +: BYTE_W]);
                  check_field({lane_name[s], "_scaled"}, int'($signed(want.scaled[s])),
                              int'($signed(rsp_tdata[48 + BYTE_W*s +: BYTE_W])));
               end
            end
         end
      end
      pending <= expected_reports.size();
      fail_count <= mismatches;
   end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import grd_pkg::*;

   localparam int RANDOM_REPORTS = 450;
   localparam int CYCLE_LIMIT    = 400000;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        rsp_tuser;
   int          fail_count;
   int          pending;

   logic        quiet = 1'b0;
   int          stall_left = 0;
   int          cycles = 0;
   int          sent = 0;
   int          analog_sent = 0;
   int          entries = 0;
   int          drains = 0;
   int          directed_count;
   logic        last_analog = 1'b0;

   gamepad_report_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   report_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
         $display("Test completed with failures");
         $finish;
      end
   end

   // mostly short stalls, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(10, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= pick_gap() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [7:0] digital_id();
      logic [7:0] v;
      v = 8'($urandom_range(0, 255));
      if (v == ANALOG_ID) v = 8'h41;
      return v;
   endfunction

   function automatic logic [7:0] pick_buttons();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Stick bytes arrive bit-reversed: 0xFE is position 127, 0x01 is 128,
   // 0x80 is 1 and 0x7F is 254.
   function automatic logic [7:0] pick_stick();
      case ($urandom_range(0, 11))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'hFE;
         3: return 8'h01;
         4: return 8'h80;
         5: return 8'h7F;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_report(input logic [7:0] id, input logic [7:0] lo, input logic [7:0] hi,
                              input logic [7:0] rh, input logic [7:0] rv,
                              input logic [7:0] lh, input logic [7:0] lv);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 1) == 1) gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {lv, lh, rv, rh, hi, lo, id};
      do @(posedge clock); while (!req_tready);
      sent++;
      if (id == ANALOG_ID) begin
         analog_sent++;
         if (!last_analog) entries++;
      end
      last_analog = (id == ANALOG_ID);
   endtask

   task automatic send_random(input logic [7:0] id);
      send_report(id, pick_buttons(), pick_buttons(), pick_stick(), pick_stick(),
                  pick_stick(), pick_stick());
   endtask

   // Hold the request side until every outstanding result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      drains++;
   endtask

   initial begin
      int kind;
      int run;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // digital mode with zero centers: every scaled value is zero
      send_report(8'h41, 8'hFF, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h7F);
      send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF);
      send_report(8'hFF, 8'hAA, 8'h55, 8'h5A, 8'hA5, 8'h3C, 8'hC3);
      // enter analog: centers 127, 128, 0, 255
      send_report(ANALOG_ID, 8'h55, 8'hAA, 8'hFE, 8'h01, 8'h00, 8'hFF);
      send_report(ANALOG_ID, 8'hFE, 8'h7F, 8'h00, 8'hFF, 8'h01, 8'hFE);
      send_report(ANALOG_ID, 8'h01, 8'h80, 8'hFF, 8'h00, 8'hFF, 8'h00);
      send_report(ANALOG_ID, 8'h0F, 8'hF0, 8'h12, 8'h9C, 8'h6B, 8'hE4);
      // ids one bit away from analog drop out of it, centers stay
      send_report(8'hCF, 8'h80, 8'h01, 8'h80, 8'h7F, 8'h80, 8'h7F);
      send_report(8'h4E, 8'h7F, 8'hFE, 8'hFF, 8'h00, 8'h33, 8'hCC);
      // re-enter: centers 1, 254, 1, 254 (unit range)
      send_report(ANALOG_ID, 8'hEE, 8'h77, 8'h80, 8'h7F, 8'h80, 8'h7F);
      send_report(ANALOG_ID, 8'h11, 8'h88, 8'h00, 8'hFF, 8'hFF, 8'h00);
      send_report(ANALOG_ID, 8'hC0, 8'h03, 8'h80, 8'h7F, 8'h40, 8'h20);
      send_report(8'h73, 8'h01, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00);
      // re-enter at mid positions 64, 192, 100, 155
      send_report(ANALOG_ID, 8'h00, 8'hFF, 8'h02, 8'h03, 8'h26, 8'hD9);
      send_report(ANALOG_ID, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00);
      send_report(ANALOG_ID, 8'h96, 8'h69, 8'hFE, 8'h01, 8'hAB, 8'h54);
      send_report(ANALOG_ID, 8'h24, 8'h42, 8'h82, 8'h83, 8'h66, 8'h99);
      directed_count = sent;
      drain_results();

      while (sent < directed_count + RANDOM_REPORTS) begin
         quiet <= ($urandom_range(0, 7) == 0);
         kind = $urandom_range(0, 19);
         if (kind < 13) begin
            // analog session: digital beat, entry beat, then a run of mostly analog beats
            send_random(digital_id());
            send_random(ANALOG_ID);
            run = $urandom_range(1, 12);
            repeat (run) begin
               if ($urandom_range(0, 15) == 0) send_random(digital_id());
               else send_random(ANALOG_ID);
            end
         end else if (kind < 18) begin
            run = $urandom_range(1, 4);
            repeat (run) send_random(digital_id());
         end else if (kind == 18) begin
            send_random(8'($urandom_range(0, 255)));
         end else begin
            drain_results();
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      $display("Covered %0d poll reports (%0d directed), %0d in analog mode, %0d analog entries,",
               sent, directed_count, analog_sent, entries);
      $display("with random stalls on both channels and %0d full drains", drains + 1);
      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[gamepad_report_decoder.f]
+incdir+sv
sv/grd_pkg.sv
sv/grd_ctrl.sv
sv/grd_datapath.sv
sv/gamepad_report_decoder.sv
dv/report_checker.sv
dv/testbench.sv
